### rtl/core/cbta_pkg.sv
`default_nettype none

package cbta_pkg;

  localparam int FACE_COUNT      = 6;
  localparam int FACE_W          = 3;
  localparam logic [FACE_W-1:0] FACE_LAST = 3'd5;
  localparam int MIN_FACE_SIZE   = 16;
  localparam int RESET_FACE_SIZE = 512;
  localparam int CFG_W           = 12;
  localparam int COORD_W         = 20;
  localparam int FRAC_W          = 8;
  localparam int ADDR_W          = 27;
  localparam int TEXEL_W         = ADDR_W - 2;
  localparam int WEIGHT_W        = 9;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;
  localparam int IN_TDATA_W      = 48;
  localparam int OUT_TDATA_W     = 144;
  localparam int NUM_TAPS        = 4;

  // tap slots
  localparam int TAP_BL = 0;
  localparam int TAP_BR = 1;
  localparam int TAP_TL = 2;
  localparam int TAP_TR = 3;

  // register indexes
  localparam logic [1:0] REG_FACE_WIDTH      = 2'd0;
  localparam logic [1:0] REG_FACE_HEIGHT     = 2'd1;
  localparam logic [1:0] REG_BILINEAR_ENABLE = 2'd2;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    dir_t              out_dir;
    dir_t              in_dir;
    logic              crossed;
  } route_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] tr;
    logic [WEIGHT_W-1:0] tl;
    logic [WEIGHT_W-1:0] br;
    logic [WEIGHT_W-1:0] bl;
  } weights_t;

  typedef struct packed {
    logic ld_remap;
    logic ld_mult;
    logic ld_out;
  } stage_en_t;

  // neighbor face across each edge, indexed [face][direction]
  localparam logic [FACE_W-1:0] ADJ_FACE [FACE_COUNT][4] = '{
    '{3'd4, 3'd3, 3'd2, 3'd1},
    '{3'd0, 3'd2, 3'd5, 3'd4},
    '{3'd0, 3'd3, 3'd5, 3'd1},
    '{3'd0, 3'd4, 3'd5, 3'd2},
    '{3'd0, 3'd1, 3'd5, 3'd3},
    '{3'd2, 3'd3, 3'd4, 3'd1}
  };

  // edge of the neighbor face where the tap lands
  localparam dir_t ENTRY_DIR [FACE_COUNT][4] = '{
    '{DIR_DOWN,  DIR_DOWN,  DIR_DOWN,  DIR_DOWN},
    '{DIR_LEFT,  DIR_LEFT,  DIR_LEFT,  DIR_RIGHT},
    '{DIR_UP,    DIR_LEFT,  DIR_DOWN,  DIR_RIGHT},
    '{DIR_RIGHT, DIR_LEFT,  DIR_RIGHT, DIR_RIGHT},
    '{DIR_DOWN,  DIR_LEFT,  DIR_UP,    DIR_RIGHT},
    '{DIR_UP,    DIR_UP,    DIR_UP,    DIR_UP}
  };

  // walk the edge crossings in the order right, up, left, down
  function automatic route_t cbta_route(input logic [FACE_W-1:0] face,
                                        input logic cr, input logic ct,
                                        input logic cl, input logic cb);
    route_t            r;
    logic [FACE_W-1:0] f;
    f         = face;
    r.out_dir = DIR_UP;
    r.in_dir  = DIR_UP;
    r.crossed = 1'b0;
    if (cr) begin
      r.in_dir  = ENTRY_DIR[f][DIR_RIGHT];
      f         = ADJ_FACE[f][DIR_RIGHT];
      r.out_dir = DIR_RIGHT;
      r.crossed = 1'b1;
    end
    if (ct) begin
      r.in_dir  = ENTRY_DIR[f][DIR_UP];
      f         = ADJ_FACE[f][DIR_UP];
      r.out_dir = DIR_UP;
      r.crossed = 1'b1;
    end
    if (cl) begin
      r.in_dir  = ENTRY_DIR[f][DIR_LEFT];
      f         = ADJ_FACE[f][DIR_LEFT];
      r.out_dir = DIR_LEFT;
      r.crossed = 1'b1;
    end
    if (cb) begin
      r.in_dir  = ENTRY_DIR[f][DIR_DOWN];
      f         = ADJ_FACE[f][DIR_DOWN];
      r.out_dir = DIR_DOWN;
      r.crossed = 1'b1;
    end
    r.face = f;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/cbta_tap_path.sv
`default_nettype none

module cbta_tap_path #(
  parameter int SW = 12,
  parameter int PW = 15
) (
  input  wire                          clk,
  input  wire  cbta_pkg::stage_en_t    en,
  input  wire  [SW-1:0]                face_w,
  input  wire  [SW-1:0]                face_h,
  input  wire  [PW-1:0]                pitch,
  input  wire  [SW-1:0]                tap_x,
  input  wire  [SW-1:0]                tap_y,
  input  wire  cbta_pkg::route_t       route,
  output logic [cbta_pkg::ADDR_W-1:0]  addr
);
  import cbta_pkg::*;

  logic [SW-1:0]      wm1;
  logic [SW-1:0]      hm1;
  logic [SW-1:0]      side;
  logic [SW-1:0]      lim_m1;
  logic [SW-1:0]      px_nxt;
  logic [SW-1:0]      py_nxt;

  logic [SW-1:0]      px_r;
  logic [SW-1:0]      py_r;
  logic [FACE_W-1:0]  face_r;

  logic [SW+PW-1:0]   row_full;
  logic [SW+2:0]      fbase_full;
  logic [TEXEL_W-1:0] row_r;
  logic [SW+2:0]      fbase_r;
  logic [SW-1:0]      col_r;

  logic [TEXEL_W-1:0] texel_sum;
  logic [ADDR_W-1:0]  addr_r;

  assign wm1 = face_w - SW'(1);
  assign hm1 = face_h - SW'(1);

  // place a tap that left the face on the entry edge of the final face
  always_comb begin
    side   = '0;
    lim_m1 = hm1;
    px_nxt = tap_x;
    py_nxt = tap_y;
    if (route.crossed) begin
      unique case (route.out_dir)
        DIR_DOWN:  side = tap_x;
        DIR_RIGHT: side = tap_y;
        DIR_UP:    side = wm1 - tap_x;
        DIR_LEFT:  side = hm1 - tap_y;
      endcase
      lim_m1 = (route.in_dir == DIR_DOWN || route.in_dir == DIR_UP) ? wm1 : hm1;
      if (side > lim_m1) begin
        side = lim_m1;
      end
      unique case (route.in_dir)
        DIR_DOWN: begin
          px_nxt = wm1 - side;
          py_nxt = '0;
        end
        DIR_RIGHT: begin
          px_nxt = wm1;
          py_nxt = hm1 - side;
        end
        DIR_UP: begin
          px_nxt = side;
          py_nxt = hm1;
        end
        DIR_LEFT: begin
          px_nxt = '0;
          py_nxt = side;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld_remap) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      face_r <= route.face;
    end
  end

  assign row_full   = (SW+PW)'(py_r) * (SW+PW)'(pitch);
  assign fbase_full = (SW+3)'(face_r) * (SW+3)'(face_w);

  always_ff @(posedge clk) begin
    if (en.ld_mult) begin
      row_r   <= TEXEL_W'(row_full);
      fbase_r <= fbase_full;
      col_r   <= px_r;
    end
  end

  assign texel_sum = row_r + TEXEL_W'(fbase_r) + TEXEL_W'(col_r);

  // four bytes per texel
  always_ff @(posedge clk) begin
    if (en.ld_out) begin
      addr_r <= {texel_sum, 2'b00};
    end
  end

  assign addr = addr_r;

endmodule

`default_nettype wire

### rtl/core/cubemap_bilinear_tap_address_top.sv
// Cubemap bilinear tap address generator.
// Input stream: one sample position per item, in_tdata holds face index,
// x and y in unsigned 8-fraction-bit fixed point. Output stream: the four
// texel byte addresses of the bilinear footprint in a six-face side-by-side
// RGBA texture, plus the four weights in 1/256 units. Taps that fall off a
// face edge are redirected onto the neighboring face's edge.
// Configuration: cfg_we/cfg_addr/cfg_wdata write face width, face height
// and the bilinear enable; sizes are clamped to 16..MAX_FACE_SIZE on write.
// Change configuration only while no items are in flight.
// The pipeline has six register stages (input, clamp, edge crossing,
// edge remap, row multiply, address add). Throughput: one item per
// cycle while out_tready is high.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// 512x512 bilinear setup. When out_tready is low the result holds on the
// output and items keep moving into empty stages behind it; in_tready drops
// only once every stage holds an item.
`default_nettype none

module cubemap_bilinear_tap_address_top #(
  parameter int MAX_FACE_SIZE = 2048
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // face_index[2:0], coord_x_q8[22:3], coord_y_q8[42:23], zero pad
  input  wire  [cbta_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // addr_bottom_left, addr_bottom_right, addr_top_left, addr_top_right
  // (27 bits each), weight_bottom_left, weight_bottom_right,
  // weight_top_left, weight_top_right (9 bits each)
  output logic [cbta_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  wire                                 cfg_we,
  input  wire  [1:0]                          cfg_addr,
  input  wire  [cbta_pkg::CFG_W-1:0]          cfg_wdata
);
  import cbta_pkg::*;

  localparam int SW        = $clog2(MAX_FACE_SIZE + 1);
  localparam int PW        = SW + 3;
  localparam int XW        = (SW + FRAC_W > COORD_W) ? SW + FRAC_W : COORD_W;
  localparam int CMPW      = (SW > CFG_W) ? SW : CFG_W;
  localparam int RST_SIZE  = (RESET_FACE_SIZE > MAX_FACE_SIZE) ? MAX_FACE_SIZE
                                                              : RESET_FACE_SIZE;
  localparam int RST_PITCH = RST_SIZE * FACE_COUNT;
  localparam int NSTG      = 6;

  // configuration
  logic [SW-1:0]   w_r;
  logic [SW-1:0]   h_r;
  logic [PW-1:0]   pitch_r;
  logic            bil_r;
  logic [CMPW-1:0] wd_ext;
  logic [CMPW-1:0] wd_clamp;
  logic [SW-1:0]   size_nxt;
  logic [PW-1:0]   pitch_nxt;

  // pipeline control
  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   rdy;

  // stage 1
  logic [FACE_W-1:0]  s1_face_r;
  logic [COORD_W-1:0] s1_cx_r;
  logic [COORD_W-1:0] s1_cy_r;
  logic [FACE_W-1:0]  face_c;
  logic [XW-1:0]      xlim;
  logic [XW-1:0]      ylim;
  logic [XW-1:0]      cxc;
  logic [XW-1:0]      cyc;

  // stage 2
  logic [FACE_W-1:0]  s2_face_r;
  logic [SW-1:0]      s2_xi_r;
  logic [SW-1:0]      s2_yi_r;
  logic               s2_xh_r;
  logic               s2_yh_r;
  logic [7:0]         s2_dx_r;
  logic [7:0]         s2_dy_r;
  logic [SW-1:0]      wm1;
  logic [SW-1:0]      hm1;
  logic [SW-1:0]      ix;
  logic [SW-1:0]      iy;
  logic               cl;
  logic               cr;
  logic               cb;
  logic               ct;
  logic [SW-1:0]      xl;
  logic [SW-1:0]      xr;
  logic [SW-1:0]      yb;
  logic [SW-1:0]      yt;
  logic [SW-1:0]      nx;
  logic [SW-1:0]      ny;
  logic [15:0]        prod_nxt;
  logic [SW-1:0]      x_nxt     [NUM_TAPS];
  logic [SW-1:0]      y_nxt     [NUM_TAPS];
  route_t             route_nxt [NUM_TAPS];

  // stage 3
  logic [SW-1:0]      s3_x_r     [NUM_TAPS];
  logic [SW-1:0]      s3_y_r     [NUM_TAPS];
  route_t             s3_route_r [NUM_TAPS];
  logic [15:0]        s3_prod_r;
  logic [7:0]         s3_dx_r;
  logic [7:0]         s3_dy_r;
  logic [WEIGHT_W-1:0] wtr;
  logic [9:0]         wbl_full;
  weights_t           wt_nxt;

  // stages 4 to 6
  weights_t           s4_wt_r;
  weights_t           s5_wt_r;
  weights_t           s6_wt_r;
  stage_en_t          tap_en;
  logic [ADDR_W-1:0]  tap_addr [NUM_TAPS];

  // ---------------- configuration ----------------
  always_comb begin
    wd_ext = CMPW'(cfg_wdata);
    if (wd_ext < CMPW'(MIN_FACE_SIZE)) begin
      wd_clamp = CMPW'(MIN_FACE_SIZE);
    end else if (wd_ext > CMPW'(MAX_FACE_SIZE)) begin
      wd_clamp = CMPW'(MAX_FACE_SIZE);
    end else begin
      wd_clamp = wd_ext;
    end
    size_nxt  = SW'(wd_clamp);
    pitch_nxt = PW'(size_nxt) * PW'(FACE_COUNT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r     <= SW'(RST_SIZE);
      h_r     <= SW'(RST_SIZE);
      pitch_r <= PW'(RST_PITCH);
      bil_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FACE_WIDTH: begin
          w_r     <= size_nxt;
          pitch_r <= pitch_nxt;
        end
        REG_FACE_HEIGHT: begin
          h_r <= size_nxt;
        end
        REG_BILINEAR_ENABLE: begin
          bil_r <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------- pipeline flow ----------------
  // a stage takes a new item when it is empty or its item moves on
  always_comb begin
    rdy[NSTG] = out_tready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NSTG-1];

  // ---------------- stage 1: input register ----------------
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_face_r <= in_tdata[FACE_W-1:0];
      s1_cx_r   <= in_tdata[FACE_W+COORD_W-1:FACE_W];
      s1_cy_r   <= in_tdata[FACE_W+2*COORD_W-1:FACE_W+COORD_W];
    end
  end

  // ---------------- stage 2: clamp, split integer and fraction ----------------
  always_comb begin
    face_c = (s1_face_r > FACE_LAST) ? FACE_LAST : s1_face_r;
    xlim   = XW'({w_r, 8'h00});
    ylim   = XW'({h_r, 8'h00});
    cxc    = (XW'(s1_cx_r) > xlim) ? xlim : XW'(s1_cx_r);
    cyc    = (XW'(s1_cy_r) > ylim) ? ylim : XW'(s1_cy_r);
  end

  // adding half a texel only flips bit 7 of the fraction and carries into the integer
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_face_r <= face_c;
      s2_xi_r   <= SW'(cxc[XW-1:FRAC_W]);
      s2_yi_r   <= SW'(cyc[XW-1:FRAC_W]);
      s2_xh_r   <= cxc[7];
      s2_yh_r   <= cyc[7];
      s2_dx_r   <= {~cxc[7], cxc[6:0]};
      s2_dy_r   <= {~cyc[7], cyc[6:0]};
    end
  end

  // ---------------- stage 3: edge crossings per tap ----------------
  assign wm1 = w_r - SW'(1);
  assign hm1 = h_r - SW'(1);

  always_comb begin
    ix = s2_xi_r + SW'(s2_xh_r);
    iy = s2_yi_r + SW'(s2_yh_r);
    cl = (ix == '0);
    cr = (ix == w_r);
    cb = (iy == '0);
    ct = (iy == h_r);
    // coordinates wrapped onto the face, used along the crossed edge
    xl = cl ? wm1 : ix - SW'(1);
    xr = cr ? '0 : ix;
    yb = cb ? hm1 : iy - SW'(1);
    yt = ct ? '0 : iy;
    nx = (s2_xi_r == w_r) ? wm1 : s2_xi_r;
    ny = (s2_yi_r == h_r) ? hm1 : s2_yi_r;
    prod_nxt = {8'h00, s2_dx_r} * {8'h00, s2_dy_r};
    if (bil_r) begin
      x_nxt[TAP_BL]     = xl;
      y_nxt[TAP_BL]     = yb;
      route_nxt[TAP_BL] = cbta_route(s2_face_r, 1'b0, 1'b0, cl, cb);
      x_nxt[TAP_BR]     = xr;
      y_nxt[TAP_BR]     = yb;
      route_nxt[TAP_BR] = cbta_route(s2_face_r, cr, 1'b0, 1'b0, cb);
      x_nxt[TAP_TL]     = xl;
      y_nxt[TAP_TL]     = yt;
      route_nxt[TAP_TL] = cbta_route(s2_face_r, 1'b0, ct, cl, 1'b0);
      x_nxt[TAP_TR]     = xr;
      y_nxt[TAP_TR]     = yt;
      route_nxt[TAP_TR] = cbta_route(s2_face_r, cr, ct, 1'b0, 1'b0);
    end else begin
      for (int t = 0; t < NUM_TAPS; t++) begin
        x_nxt[t]     = nx;
        y_nxt[t]     = ny;
        route_nxt[t] = '{face: s2_face_r, out_dir: DIR_UP, in_dir: DIR_UP,
                         crossed: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int t = 0; t < NUM_TAPS; t++) begin
        s3_x_r[t]     <= x_nxt[t];
        s3_y_r[t]     <= y_nxt[t];
        s3_route_r[t] <= route_nxt[t];
      end
      s3_prod_r <= prod_nxt;
      s3_dx_r   <= s2_dx_r;
      s3_dy_r   <= s2_dy_r;
    end
  end

  // ---------------- weights ----------------
  always_comb begin
    wtr      = WEIGHT_W'((s3_prod_r + 16'd128) >> 8);
    wbl_full = 10'(WEIGHT_ONE) - {2'b00, s3_dx_r} - {2'b00, s3_dy_r} + {1'b0, wtr};
    if (bil_r) begin
      wt_nxt.tr = wtr;
      wt_nxt.br = {1'b0, s3_dx_r} - wtr;
      wt_nxt.tl = {1'b0, s3_dy_r} - wtr;
      wt_nxt.bl = wbl_full[WEIGHT_W-1:0];
    end else begin
      wt_nxt.tr = '0;
      wt_nxt.br = '0;
      wt_nxt.tl = '0;
      wt_nxt.bl = WEIGHT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_wt_r <= wt_nxt;
    end
    if (rdy[4]) begin
      s5_wt_r <= s4_wt_r;
    end
    if (rdy[5]) begin
      s6_wt_r <= s5_wt_r;
    end
  end

  // ---------------- stages 4 to 6: per-tap address ----------------
  assign tap_en = '{ld_remap: rdy[3], ld_mult: rdy[4], ld_out: rdy[5]};

  for (genvar t = 0; t < NUM_TAPS; t++) begin : g_tap
    cbta_tap_path #(
      .SW (SW),
      .PW (PW)
    ) u_tap (
      .clk    (clk),
      .en     (tap_en),
      .face_w (w_r),
      .face_h (h_r),
      .pitch  (pitch_r),
      .tap_x  (s3_x_r[t]),
      .tap_y  (s3_y_r[t]),
      .route  (s3_route_r[t]),
      .addr   (tap_addr[t])
    );
  end

  assign out_tdata = {s6_wt_r.tr, s6_wt_r.tl, s6_wt_r.br, s6_wt_r.bl,
                      tap_addr[TAP_TR], tap_addr[TAP_TL],
                      tap_addr[TAP_BR], tap_addr[TAP_BL]};

endmodule

`default_nettype wire

### rtl/core/cbta_checker.sv
`default_nettype none

module cbta_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [cbta_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import cbta_pkg::*;

  localparam int WBASE = NUM_TAPS * ADDR_W;

  logic [WEIGHT_W+1:0] wsum;
  logic                addr_aligned;

  assign wsum = (WEIGHT_W+2)'(out_tdata[WBASE +: WEIGHT_W])
              + (WEIGHT_W+2)'(out_tdata[WBASE + WEIGHT_W +: WEIGHT_W])
              + (WEIGHT_W+2)'(out_tdata[WBASE + 2*WEIGHT_W +: WEIGHT_W])
              + (WEIGHT_W+2)'(out_tdata[WBASE + 3*WEIGHT_W +: WEIGHT_W]);

  // every tap is a whole rgba texel
  assign addr_aligned = (out_tdata[1:0] == 2'b00)
                     && (out_tdata[ADDR_W +: 2] == 2'b00)
                     && (out_tdata[2*ADDR_W +: 2] == 2'b00)
                     && (out_tdata[3*ADDR_W +: 2] == 2'b00);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> wsum == (WEIGHT_W+2)'(WEIGHT_ONE))
    else $error("tap weights do not sum to one");

  a_addr_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> addr_aligned)
    else $error("tap address not texel aligned");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output item changed");

endmodule

bind cubemap_bilinear_tap_address_top cbta_checker u_cbta_checker (.*);

`default_nettype wire
